FILE: hdl/mpwa_pkg.sv
package mpwa_pkg;

    localparam int unsigned MAX_ELEMENTS_DEF = 4096;
    localparam int unsigned MAX_KERNEL_DEF   = 8;

    localparam int unsigned VAL_W    = 64;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned CFG_IX_W = 3;
    localparam int unsigned CFG_D_W  = 7;
    localparam int unsigned ROW_W    = 13;
    localparam int unsigned RC_W     = 14;
    localparam int unsigned ADDR_W   = 21;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_POOL  = 1'b1;

    localparam logic [CFG_IX_W-1:0] CFG_KERNEL   = 3'd0;
    localparam logic [CFG_IX_W-1:0] CFG_STEP     = 3'd1;
    localparam logic [CFG_IX_W-1:0] CFG_PAD      = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [CFG_IX_W-1:0] CFG_WIDTH    = 3'd4;
    localparam logic [CFG_IX_W-1:0] CFG_CHANNELS = 3'd5;

    localparam logic [3:0] KERNEL_RST   = 4'd2;
    localparam logic [3:0] STEP_RST     = 4'd2;
    localparam logic [2:0] PAD_RST      = 3'd0;
    localparam logic [6:0] HEIGHT_RST   = 7'd8;
    localparam logic [6:0] WIDTH_RST    = 7'd8;
    localparam logic [6:0] CHANNELS_RST = 7'd1;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic                    command;
        logic [5:0]              in_row;
        logic [5:0]              in_col;
        logic [6:0]              out_row;
        logic [6:0]              out_col;
        logic [5:0]              channel;
        logic signed [VAL_W-1:0] elem_value;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] max_value;
        logic [IDX_W-1:0]        window_index;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DRAIN
    } t_state;

endpackage

FILE: hdl/max_pool_window_argmax_unit.sv
// Max pooling with argmax over one stored feature map.
//
// Input channel (i_in_valid / o_in_ready, i_in_word): a write word stores one
// element at (in_row, in_col, channel); a pool word scans the kernel window
// of output position (out_row, out_col, channel) and returns one output word
// with the window maximum and the index of its first occurrence.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is
// always ready; write it only while the block is idle.
// Output channel (o_out_valid / i_out_ready, o_out_word) is registered.
//
// One window position is issued per cycle into a four-stage address and
// read pipeline in front of the single-port store. A pool word scans its
// k*k window positions (k = kernel size), a write word one position; the
// next word is taken once the pipeline is empty. A waiting output word
// does not block new input; only a finished pool word waits while the
// receiver stalls.
// Reset restores the register defaults and empties the pipeline and output;
// the store is not cleared.
module max_pool_window_argmax_unit #(
    parameter int unsigned MAX_ELEMENTS = mpwa_pkg::MAX_ELEMENTS_DEF,
    parameter int unsigned MAX_KERNEL   = mpwa_pkg::MAX_KERNEL_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mpwa_pkg::t_in_word                i_in_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mpwa_pkg::CFG_IX_W-1:0]     i_cfg_index,
    input  logic [mpwa_pkg::CFG_D_W-1:0]      i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mpwa_pkg::t_out_word               o_out_word
);
    import mpwa_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam int unsigned KW = $clog2(MAX_KERNEL + 1);
    localparam int unsigned PW = (2 * KW > IDX_W) ? 2 * KW : IDX_W;

    logic [3:0] r_kernel;
    logic [3:0] r_step;
    logic [2:0] r_pad;
    logic [6:0] r_height;
    logic [6:0] r_width;
    logic [6:0] r_chan;

    t_state   r_state, n_state;
    t_in_word r_in;

    logic [ROW_W-1:0] r_r0, r_c0;
    logic [KW-1:0]    r_k, r_m, r_n;
    logic [PW-1:0]    r_pos;

    logic             r_a_live, r_a_ok;
    logic [6:0]       r_a_row, r_a_col;
    logic [PW-1:0]    r_a_pos;
    logic             r_b_live, r_b_ok;
    logic [RC_W-1:0]  r_b_rc;
    logic [PW-1:0]    r_b_pos;
    logic             r_c_live, r_c_ok;
    logic [ADDR_W-1:0] r_c_addr;
    logic [PW-1:0]    r_c_pos;
    logic             r_d_live, r_d_ok;
    logic [VAL_W-1:0] r_d_data;
    logic [PW-1:0]    r_d_pos;

    logic signed [VAL_W-1:0] r_best;
    logic [PW-1:0]           r_best_idx;
    logic                    r_out_valid;
    t_out_word               r_out_word;

    logic [VAL_W-1:0] mem [MAX_ELEMENTS];

    logic             w_issue, w_load, w_busy, w_last, w_is_write;
    logic [KW-1:0]    w_k_eff, w_k_start;
    logic [ROW_W-1:0] w_row, w_col, w_r0, w_c0;
    logic             w_ok;
    logic [RC_W-1:0]  w_rc;
    logic [ADDR_W-1:0] w_addr;
    logic signed [VAL_W-1:0] w_cand;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_is_write = (r_in.command == CMD_WRITE);
    assign w_busy     = r_a_live || r_b_live || r_c_live || r_d_live;
    assign w_k_eff    = ({1'b0, r_kernel} > 5'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(r_kernel);
    assign w_k_start  = w_is_write ? KW'(1) : w_k_eff;
    assign w_last     = (r_m == KW'(r_k - KW'(1))) && (r_n == KW'(r_k - KW'(1)));

    assign w_r0 = w_is_write ? ROW_W'(r_in.in_row)
                : ROW_W'(ROW_W'(r_in.out_row) * ROW_W'(r_step) - ROW_W'(r_pad));
    assign w_c0 = w_is_write ? ROW_W'(r_in.in_col)
                : ROW_W'(ROW_W'(r_in.out_col) * ROW_W'(r_step) - ROW_W'(r_pad));

    assign w_row = ROW_W'(r_r0 + ROW_W'(r_m));
    assign w_col = ROW_W'(r_c0 + ROW_W'(r_n));
    assign w_ok  = !w_row[ROW_W-1] && (w_row < ROW_W'(r_height))
                && !w_col[ROW_W-1] && (w_col < ROW_W'(r_width))
                && ({1'b0, r_in.channel} < r_chan);

    assign w_rc   = RC_W'(RC_W'(r_a_row) * RC_W'(r_width) + RC_W'(r_a_col));
    assign w_addr = ADDR_W'(ADDR_W'(r_b_rc) * ADDR_W'(r_chan) + ADDR_W'(r_in.channel));
    assign w_cand = r_d_ok ? $signed(r_d_data) : '0;

    always_comb begin
        n_state    = r_state;
        w_issue    = 1'b0;
        w_load     = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = (w_k_start == '0) ? S_DRAIN : S_SCAN;
            end
            S_SCAN: begin
                w_issue = 1'b1;
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_busy) begin
                    if (w_is_write) begin
                        n_state = S_IDLE;
                    end else if (!r_out_valid || i_out_ready) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kernel <= KERNEL_RST;
            r_step   <= STEP_RST;
            r_pad    <= PAD_RST;
            r_height <= HEIGHT_RST;
            r_width  <= WIDTH_RST;
            r_chan   <= CHANNELS_RST;
            r_a_live <= 1'b0;
            r_b_live <= 1'b0;
            r_c_live <= 1'b0;
            r_d_live <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_a_live <= w_issue;
            r_b_live <= r_a_live;
            r_c_live <= r_b_live;
            r_d_live <= r_c_live;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KERNEL:   r_kernel <= i_cfg_data[3:0];
                    CFG_STEP:     r_step   <= i_cfg_data[3:0];
                    CFG_PAD:      r_pad    <= i_cfg_data[2:0];
                    CFG_HEIGHT:   r_height <= i_cfg_data;
                    CFG_WIDTH:    r_width  <= i_cfg_data;
                    CFG_CHANNELS: r_chan   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (r_state == S_SETUP) begin
            r_k        <= w_k_start;
            r_m        <= '0;
            r_n        <= '0;
            r_pos      <= '0;
            r_r0       <= w_r0;
            r_c0       <= w_c0;
            r_best     <= VAL_MIN;
            r_best_idx <= '0;
        end else begin
            if (w_issue) begin
                r_pos <= PW'(r_pos + PW'(1));
                if (r_n == KW'(r_k - KW'(1))) begin
                    r_n <= '0;
                    r_m <= KW'(r_m + KW'(1));
                end else begin
                    r_n <= KW'(r_n + KW'(1));
                end
            end
            if (r_d_live && (w_cand > r_best)) begin
                r_best     <= w_cand;
                r_best_idx <= r_d_pos;
            end
        end
        r_a_ok  <= w_ok;
        r_a_row <= w_row[6:0];
        r_a_col <= w_col[6:0];
        r_a_pos <= r_pos;
        r_b_ok  <= r_a_ok;
        r_b_rc  <= w_rc;
        r_b_pos <= r_a_pos;
        r_c_ok  <= r_b_ok && (w_addr < ADDR_W'(MAX_ELEMENTS));
        r_c_addr <= w_addr;
        r_c_pos <= r_b_pos;
        r_d_ok  <= r_c_ok;
        r_d_pos <= r_c_pos;
        if (w_load) begin
            r_out_word.max_value    <= r_best;
            r_out_word.window_index <= r_best_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_live && r_c_ok && w_is_write) begin
            mem[r_c_addr[AW-1:0]] <= r_in.elem_value;
        end
        r_d_data <= mem[r_c_addr[AW-1:0]];
    end

`ifndef SYNTHESIS
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(r_a_live || r_b_live || r_c_live || r_d_live))
        else $error("input taken while pipeline busy");

    a_issue_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_live |-> $past(r_state == S_SCAN))
        else $error("position issued outside scan");

    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_live && w_is_write) |-> (r_a_pos == '0))
        else $error("write scanned more than one position");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && w_is_write) |=> !$rose(r_out_valid))
        else $error("write produced an output word");
`endif

endmodule
